### hdl/tle_pkg.sv
// Shared types and constants of the terminal line editor.
// Result action codes, the byte codes that the decoder reacts to, and the
// structs that pass between the decoder, the line memory and the top level.
package tle_pkg;

	localparam int FILL_W = 6;

	localparam logic [2:0] ACT_ECHO   = 3'd0;
	localparam logic [2:0] ACT_LEFT   = 3'd1;
	localparam logic [2:0] ACT_RIGHT  = 3'd2;
	localparam logic [2:0] ACT_DELETE = 3'd3;
	localparam logic [2:0] ACT_ERASE  = 3'd4;
	localparam logic [2:0] ACT_CANCEL = 3'd5;
	localparam logic [2:0] ACT_SUBMIT = 3'd6;
	localparam logic [2:0] ACT_CHAR   = 3'd7;

	localparam logic [7:0] BYTE_ETX   = 8'd3;
	localparam logic [7:0] BYTE_BS    = 8'd8;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] BYTE_ESC   = 8'd27;
	localparam logic [7:0] BYTE_DEL   = 8'd127;
	localparam logic [7:0] BYTE_LBRK  = 8'h5B;
	localparam logic [7:0] BYTE_TILDE = 8'h7E;
	localparam logic [7:0] BYTE_THREE = 8'h33;
	localparam logic [7:0] BYTE_UPC_D = 8'h44;
	localparam logic [7:0] BYTE_UPC_C = 8'h43;

	typedef struct packed {
		logic [2:0]        action;
		logic [7:0]        char_out;
		logic [FILL_W-1:0] line_len;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              emit;
		res_t              res;
		logic              wr_en;
		logic [FILL_W-1:0] wr_cnt;
		logic [7:0]        wr_data;
		logic              submit;
	} dec_t;

endpackage

### hdl/tle_byte_if.sv
// Input channel of the terminal line editor: one received byte per transfer.
// Depends on nothing.
interface tle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/tle_res_if.sv
// Result channel of the terminal line editor: one editor action per transfer.
// Depends on nothing.
interface tle_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] char_out;
	logic [5:0] line_len;
	logic       last;

	modport source (output valid, output action, output char_out, output line_len,
		output last, input ready);
	modport sink (input valid, input action, input char_out, input line_len,
		input last, output ready);
endinterface

### hdl/tle_ctrl.sv
// Byte decoder of the terminal line editor: escape tracking and fill count.
// Depends on tle_pkg.
module tle_ctrl
	import tle_pkg::*;
#(
	parameter int LINE_CAP = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output dec_t       dec
);

	localparam logic [1:0] PH_NORMAL = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_CSI    = 2'd2;
	localparam logic [1:0] PH_DEL    = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              ordinary;

	always_comb begin
		dec      = '0;
		phase_d  = phase_q;
		fill_d   = fill_q;
		ordinary = 1'b0;
		dec.res.last = 1'b1;

		unique case (phase_q)
			PH_NORMAL: begin
				if (rx_byte == BYTE_ESC) begin
					phase_d = PH_ESC;
				end else begin
					ordinary = 1'b1;
				end
			end
			PH_ESC: begin
				if (rx_byte == BYTE_LBRK) begin
					phase_d = PH_CSI;
				end else begin
					// A broken sequence falls back to plain byte handling.
					phase_d  = PH_NORMAL;
					ordinary = 1'b1;
				end
			end
			PH_CSI: begin
				phase_d = PH_NORMAL;
				if (rx_byte == BYTE_UPC_D) begin
					dec.emit       = 1'b1;
					dec.res.action = ACT_LEFT;
				end else if (rx_byte == BYTE_UPC_C) begin
					dec.emit       = 1'b1;
					dec.res.action = ACT_RIGHT;
				end else if (rx_byte == BYTE_THREE) begin
					phase_d = PH_DEL;
				end
			end
			default: begin
				phase_d = PH_NORMAL;
				if (rx_byte == BYTE_TILDE) begin
					dec.emit       = 1'b1;
					dec.res.action = ACT_DELETE;
				end
			end
		endcase

		if (ordinary) begin
			if (rx_byte == BYTE_BS || rx_byte == BYTE_DEL) begin
				if (fill_q != '0) begin
					fill_d         = fill_q - 1'b1;
					dec.emit       = 1'b1;
					dec.res.action = ACT_ERASE;
				end
			end else if (rx_byte == BYTE_ETX) begin
				fill_d         = '0;
				dec.emit       = 1'b1;
				dec.res.action = ACT_CANCEL;
			end else if (rx_byte == BYTE_CR || rx_byte == BYTE_LF) begin
				fill_d           = '0;
				dec.emit         = 1'b1;
				dec.submit       = 1'b1;
				dec.res.action   = ACT_SUBMIT;
				dec.res.line_len = fill_q;
				dec.res.last     = (fill_q == '0);
			end else begin
				if (fill_q < FILL_W'(LINE_CAP)) begin
					dec.wr_en = 1'b1;
					fill_d    = fill_q + 1'b1;
				end
				dec.emit         = 1'b1;
				dec.res.action   = ACT_ECHO;
				dec.res.char_out = rx_byte;
			end
		end

		dec.wr_cnt  = fill_q;
		dec.wr_data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			fill_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
		end
	end

endmodule

### hdl/tle_line_mem.sv
// Line store of the terminal line editor and the sequencer that reads the
// line out after a submit. Depends on tle_pkg.
module tle_line_mem
	import tle_pkg::*;
#(
	parameter int LINE_CAP = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [FILL_W-1:0] wr_cnt,
	input  logic [7:0]        wr_data,
	input  logic              start,
	input  logic [FILL_W-1:0] start_len,
	input  logic              slot_free,
	output logic              busy,
	output logic              char_valid,
	output res_t              char_res
);

	localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [7:0]        line_mem [LINE_CAP];
	logic [7:0]        rd_data_q;
	logic [1:0]        state_q;
	logic [FILL_W-1:0] cnt_q;
	logic [FILL_W-1:0] len_q;
	logic              rd_en;
	logic              take;
	logic              final_char;

	assign rd_en      = (state_q == ST_READ);
	assign char_valid = (state_q == ST_HOLD);
	assign take       = char_valid && slot_free;
	assign final_char = (cnt_q + 1'b1) == len_q;
	assign busy       = (state_q != ST_IDLE);

	always_comb begin
		char_res          = '0;
		char_res.action   = ACT_CHAR;
		char_res.char_out = rd_data_q;
		char_res.last     = final_char;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_cnt[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= line_mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && start_len != '0) begin
						state_q <= ST_READ;
						cnt_q   <= '0;
						len_q   <= start_len;
					end
				end
				ST_READ: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (take) begin
						if (final_char) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
							cnt_q   <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The line is never written while it is being read out.
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("line store written during readout");

	// A character is shown only after a read issued in the cycle before.
	a_hold_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_valid) |-> $past(rd_en))
		else $error("character shown without a preceding read");

	// The read index stays inside the submitted line.
	a_cnt_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q < len_q))
		else $error("readout index beyond line length");

	// Reading out ends right after the final character leaves.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_char) |=> !busy)
		else $error("readout did not end after the final character");

endmodule

### hdl/terminal_line_editor.sv
// Terminal line editor: turns received bytes into editor actions.
// Depends on tle_pkg, tle_byte_if, tle_res_if, tle_ctrl and tle_line_mem.
//
//   channel  dir  payload                               transfer when
//   rx       in   rx_byte[7:0]                          rx.valid && rx.ready
//   tx       out  action[2:0] char_out line_len last    tx.valid && tx.ready
//
// The result of an ordinary byte sits in the output register, and the next byte
// is taken while that register is free or being emptied.
// A submit of n characters holds rx until the whole line has been read out:
// each character is a memory read, then a state that shows the registered data.
// Reset clears the escape phase, the fill count, the readout sequencer and the
// output valid flag; the line store needs no clearing pass.
// A stall on tx stops both the readout and the intake of new bytes.
module terminal_line_editor
	import tle_pkg::*;
#(
	parameter int LINE_CAP = 63
) (
	input logic        clk,
	input logic        arst_n,
	tle_byte_if.sink   rx,
	tle_res_if.source  tx
);

	dec_t dec;
	res_t char_res;
	res_t out_q;
	logic out_valid_q;
	logic slot_free;
	logic busy;
	logic char_valid;
	logic accept;

	assign slot_free = !out_valid_q || tx.ready;
	assign rx.ready  = !busy && slot_free;
	assign accept    = rx.valid && rx.ready;

	tle_ctrl #(
		.LINE_CAP (LINE_CAP)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.dec     (dec)
	);

	tle_line_mem #(
		.LINE_CAP (LINE_CAP)
	) u_line_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && dec.wr_en),
		.wr_cnt     (dec.wr_cnt),
		.wr_data    (dec.wr_data),
		.start      (accept && dec.submit),
		.start_len  (dec.res.line_len),
		.slot_free  (slot_free),
		.busy       (busy),
		.char_valid (char_valid),
		.char_res   (char_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (accept && dec.emit) begin
				out_valid_q <= 1'b1;
			end else if (char_valid && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (accept && dec.emit) begin
			out_q <= dec.res;
		end else if (char_valid && slot_free) begin
			out_q <= char_res;
		end
	end

	assign tx.valid    = out_valid_q;
	assign tx.action   = out_q.action;
	assign tx.char_out = out_q.char_out;
	assign tx.line_len = out_q.line_len;
	assign tx.last     = out_q.last;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for terminal_line_editor: directed table, then random line traffic.
// Depends on tle_pkg, tle_byte_if, tle_res_if and the editor RTL.
module tb;
	import tle_pkg::*;

	localparam int LINE_CAP    = 63;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS  = 500;

	typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_BRACKET, PH_THREE} esc_phase_t;

	// typed < 0: take the predicted results, 0: no result, 1: the one result given
	typedef struct {
		logic [7:0] b;
		int         typed;
		res_t       res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tle_byte_if rx_ch ();
	tle_res_if  tx_ch ();

	terminal_line_editor #(.LINE_CAP(LINE_CAP)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	esc_phase_t phase;
	logic [7:0] line_chars [LINE_CAP];
	int         fill;
	res_t       step_out [$];
	res_t       awaited_actions [$];
	int         mismatches;
	int         counted_bytes;
	int         cycles;
	bit         no_idle;

	dir_row_t directed [27] = '{
		'{BYTE_BS,    0, '0},
		'{BYTE_CR,    1, '{ACT_SUBMIT, 8'h00, 6'd0, 1'b1}},
		'{8'h00,      1, '{ACT_ECHO, 8'h00, 6'd0, 1'b1}},
		'{8'hFF,      1, '{ACT_ECHO, 8'hFF, 6'd0, 1'b1}},
		'{BYTE_DEL,   1, '{ACT_ERASE, 8'h00, 6'd0, 1'b1}},
		'{BYTE_ESC,   0, '0},
		'{BYTE_LBRK,  0, '0},
		'{BYTE_UPC_D, 1, '{ACT_LEFT, 8'h00, 6'd0, 1'b1}},
		'{BYTE_ESC,   0, '0},
		'{BYTE_LBRK,  0, '0},
		'{BYTE_UPC_C, 1, '{ACT_RIGHT, 8'h00, 6'd0, 1'b1}},
		'{BYTE_ESC,   0, '0},
		'{BYTE_LBRK,  0, '0},
		'{BYTE_THREE, 0, '0},
		'{BYTE_TILDE, 1, '{ACT_DELETE, 8'h00, 6'd0, 1'b1}},
		'{BYTE_ESC,   0, '0},
		'{BYTE_LBRK,  0, '0},
		'{8'h5A,      0, '0},
		'{BYTE_ESC,   0, '0},
		'{BYTE_LBRK,  0, '0},
		'{BYTE_THREE, 0, '0},
		'{8'h78,      0, '0},
		'{BYTE_ESC,   0, '0},
		'{BYTE_ESC,   1, '{ACT_ECHO, BYTE_ESC, 6'd0, 1'b1}},
		'{BYTE_LF,   -1, '0},
		'{8'h71,     -1, '0},
		'{BYTE_ETX,   1, '{ACT_CANCEL, 8'h00, 6'd0, 1'b1}}
	};

	function automatic res_t mk(logic [2:0] act, logic [7:0] ch, logic [5:0] len, logic lst);
		res_t r;
		r.action   = act;
		r.char_out = ch;
		r.line_len = len;
		r.last     = lst;
		return r;
	endfunction

	// Advances the editor state by one byte and leaves its actions in step_out.
	task automatic edit_line(input logic [7:0] b);
		bit plain;
		plain = 1'b0;
		step_out.delete();
		case (phase)
			PH_IDLE: begin
				if (b == BYTE_ESC) phase = PH_ESC;
				else plain = 1'b1;
			end
			PH_ESC: begin
				if (b == BYTE_LBRK) begin
					phase = PH_BRACKET;
				end else begin
					// A broken escape falls through and the byte is handled as usual.
					phase = PH_IDLE;
					plain = 1'b1;
				end
			end
			PH_BRACKET: begin
				phase = PH_IDLE;
				if (b == BYTE_UPC_D) step_out.push_back(mk(ACT_LEFT, 8'h00, 6'd0, 1'b1));
				else if (b == BYTE_UPC_C) step_out.push_back(mk(ACT_RIGHT, 8'h00, 6'd0, 1'b1));
				else if (b == BYTE_THREE) phase = PH_THREE;
			end
			default: begin
				phase = PH_IDLE;
				if (b == BYTE_TILDE) step_out.push_back(mk(ACT_DELETE, 8'h00, 6'd0, 1'b1));
			end
		endcase
		if (plain) begin
			if (b == BYTE_BS || b == BYTE_DEL) begin
				if (fill > 0) begin
					fill--;
					step_out.push_back(mk(ACT_ERASE, 8'h00, 6'd0, 1'b1));
				end
			end else if (b == BYTE_ETX) begin
				fill = 0;
				step_out.push_back(mk(ACT_CANCEL, 8'h00, 6'd0, 1'b1));
			end else if (b == BYTE_CR || b == BYTE_LF) begin
				step_out.push_back(mk(ACT_SUBMIT, 8'h00, 6'(fill), fill == 0));
				for (int i = 0; i < fill; i++)
					step_out.push_back(mk(ACT_CHAR, line_chars[i], 6'd0, i == fill - 1));
				fill = 0;
			end else begin
				if (fill < LINE_CAP) begin
					line_chars[fill] = b;
					fill++;
				end
				step_out.push_back(mk(ACT_ECHO, b, 6'd0, 1'b1));
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input int typed, input res_t typed_res);
		int gap;
		bit was_idle;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		was_idle = (phase == PH_IDLE);
		edit_line(b);
		if (typed < 0) begin
			foreach (step_out[i]) awaited_actions.push_back(step_out[i]);
		end else if (typed == 1) begin
			awaited_actions.push_back(typed_res);
		end
		// A backspace on an empty line is ignored by the block and is not counted.
		if (!(was_idle && phase == PH_IDLE && step_out.size() == 0))
			counted_bytes++;
	endtask

	// Waits at least one edge so that the next drive falls in a later time step.
	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_actions.size() != 0);
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0d: %s", cycles, msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stalls, each transfer checked against the oldest expectation.
	initial begin
		int stall;
		res_t got;
		res_t want;
		tx_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			do @(posedge clk); while (tx_ch.valid !== 1'b1);
			got = mk(tx_ch.action, tx_ch.char_out, tx_ch.line_len, tx_ch.last);
			if (awaited_actions.size() == 0) begin
				report($sformatf("unexpected result act=%0d char=%02h len=%0d last=%0d",
					got.action, got.char_out, got.line_len, got.last));
			end else begin
				want = awaited_actions.pop_front();
				if (got.action !== want.action || got.char_out !== want.char_out ||
						got.line_len !== want.line_len || got.last !== want.last)
					report($sformatf({"expected act=%0d char=%02h len=%0d last=%0d, ",
						"got act=%0d char=%02h len=%0d last=%0d"},
						want.action, want.char_out, want.line_len, want.last,
						got.action, got.char_out, got.line_len, got.last));
			end
		end
	end

	initial begin
		int kind;
		int len;
		int pick;
		logic [7:0] c;
		mismatches    = 0;
		counted_bytes = 0;
		no_idle       = 1'b0;
		phase         = PH_IDLE;
		fill          = 0;
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_byte(directed[i].b, directed[i].typed, directed[i].res);
		drain_results();
		counted_bytes = 0;

		while (counted_bytes < RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) drain_results();
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), -1, '0);
			end else if (kind == 1) begin
				// Escape sequences cut short at a random point.
				send_byte(BYTE_ESC, -1, '0);
				pick = $urandom_range(0, 2);
				if (pick > 0) send_byte(BYTE_LBRK, -1, '0);
				if (pick > 1) send_byte(BYTE_THREE, -1, '0);
				send_byte(8'($urandom_range(0, 255)), -1, '0);
			end else begin
				// A typed line with edits; now and then long enough to overflow.
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 72)
					: $urandom_range(0, 12);
				repeat (len) begin
					pick = $urandom_range(0, 11);
					if (pick == 0) begin
						send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL, -1, '0);
					end else if (pick == 1) begin
						send_byte(BYTE_ESC, -1, '0);
						send_byte(BYTE_LBRK, -1, '0);
						send_byte($urandom_range(0, 1) ? BYTE_UPC_D : BYTE_UPC_C, -1, '0);
					end else if (pick == 2) begin
						send_byte(BYTE_ESC, -1, '0);
						send_byte(BYTE_LBRK, -1, '0);
						send_byte(BYTE_THREE, -1, '0);
						send_byte(BYTE_TILDE, -1, '0);
					end else begin
						do c = 8'($urandom_range(0, 255));
						while (c == BYTE_ETX || c == BYTE_BS || c == BYTE_LF || c == BYTE_CR ||
							c == BYTE_ESC || c == BYTE_DEL);
						send_byte(c, -1, '0);
					end
				end
				pick = $urandom_range(0, 7);
				if (pick == 0) send_byte(BYTE_ETX, -1, '0);
				else send_byte(pick[0] ? BYTE_CR : BYTE_LF, -1, '0);
			end
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/tle_pkg.sv
hdl/tle_byte_if.sv
hdl/tle_res_if.sv
hdl/tle_ctrl.sv
hdl/tle_line_mem.sv
hdl/terminal_line_editor.sv
dv/tb.sv
